@@ sv/lztd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the LZ token stream decompressor.
// Holds the phase and sequencer encodings, field widths and error codes; no dependencies.

package lztd_pkg;

    // Defaults for the top-level parameters.
    localparam int HIST_DEPTH_DEF = 65536;
    localparam int OUT_LANES_DEF  = 8;

    // Fixed field widths.
    localparam int BYTE_W   = 8;
    localparam int VCOUNT_W = 4;
    localparam int ERR_W    = 2;
    localparam int LIT_W    = 8;
    localparam int MLEN_W   = 9;
    localparam int LEN_W    = 10;
    localparam int OFF_W    = 17;

    // Error codes carried on the result item.
    localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OFFSET = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TRUNC  = 2'd2;

    // Token constants.
    localparam logic [6:0]       EXT_MARK  = 7'h7f;
    localparam logic [LEN_W-1:0] MIN_MATCH = 10'd4;

    // Where the parser stands inside a token.
    typedef enum logic [4:0] {
        PH_TOKEN = 5'b00001,
        PH_LIT   = 5'b00010,
        PH_EXT   = 5'b00100,
        PH_OLO   = 5'b01000,
        PH_OHI   = 5'b10000
    } phase_t;

    // Sequencer of the copy engine.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_TRUNC = 5'b00010,
        ST_RD    = 5'b00100,
        ST_WR    = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

endpackage

@@ sv/lztd_hist_ram.sv @@
`timescale 1ns / 1ps
// History memory of the decompressor: one write port and one registered read port.
// Depends on lztd_pkg for the byte width.

module lztd_hist_ram
    import lztd_pkg::*;
#(
    parameter int  DEPTH = HIST_DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/lz_token_stream_decompressor.sv @@
`timescale 1ns / 1ps
// Top level of the LZ token stream decompressor: token parser, match copy sequencer
// and output register. Depends on lztd_pkg and lztd_hist_ram.

// The block takes one compressed byte per item and is ready again in the next
// cycle for tokens, extension bytes, low offset bytes and literals, as long as the
// output register is free or being taken; a high offset byte that starts a match,
// or a literal cut off by the end of its frame, stalls the input. A literal byte's
// result is valid in the cycle after the byte is accepted. A match reads each copied
// byte from the history memory, whose read data is registered, in ST_RD and writes
// it back in ST_WR, and sends results of up to OUT_LANES bytes from ST_EMIT; the
// input stalls meanwhile. A cut-off literal's error item follows from ST_TRUNC. The
// history needs no clearing pass after reset, so the block is ready at once.

module lz_token_stream_decompressor
    import lztd_pkg::*;
#(
    parameter int  HISTORY_DEPTH = HIST_DEPTH_DEF,
    parameter int  OUT_LANES     = OUT_LANES_DEF,
    localparam int TDATA_W       = ((OUT_LANES * BYTE_W + VCOUNT_W + 7) / 8) * 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Compressed input stream.
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic               s_axis_tlast,   // last_of_frame
    // Decompressed result stream.
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // out_byte_0 .. out_byte_N-1, valid_count, zeros
    output logic               m_axis_tlast,   // last_of_run
    output logic [ERR_W-1:0]   m_axis_tuser    // error
);

    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int BP_W   = AW + 1;
    localparam int CNT_W  = $clog2(OUT_LANES + 1);
    localparam int LANE_W = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;

    // Control and frame state.
    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [LIT_W-1:0]   lit_left_reg, lit_left_next;
    logic [MLEN_W-1:0]  mlen_reg, mlen_next;
    logic [BYTE_W-1:0]  off_lo_reg, off_lo_next;
    logic [AW-1:0]      wp_reg, wp_next;
    logic [BP_W-1:0]    bp_reg, bp_next;
    logic [LEN_W-1:0]   len_left_reg, len_left_next;
    logic [CNT_W-1:0]   lane_cnt_reg, lane_cnt_next;
    logic               last_reg, last_next;
    logic               out_valid_reg, out_valid_next;

    // Payload registers.
    logic [AW-1:0]      src_reg, src_next;
    logic [BYTE_W-1:0]  lane_reg [OUT_LANES];
    logic [BYTE_W-1:0]  out_byte_reg [OUT_LANES];
    logic [VCOUNT_W-1:0] out_cnt_reg;
    logic               out_last_reg;
    logic [ERR_W-1:0]   out_err_reg;

    // Result loading.
    logic               out_load;
    logic [BYTE_W-1:0]  load_bytes [OUT_LANES];
    logic [VCOUNT_W-1:0] load_cnt;
    logic               load_last;
    logic [ERR_W-1:0]   load_err;
    logic               lane_wr;

    // History memory port.
    logic               ram_wr_en;
    logic [BYTE_W-1:0]  ram_wr_data;
    logic               ram_rd_en;
    logic [BYTE_W-1:0]  ram_rd_data;

    // Pointer arithmetic.
    logic               out_free;
    logic               in_acc;
    logic [AW-1:0]      wp_inc;
    logic [AW-1:0]      src_inc;
    logic [BP_W-1:0]    bp_inc;
    logic [OFF_W-1:0]   off_full;
    logic [OFF_W-1:0]   bp_full;
    logic [OFF_W-1:0]   wp_full;
    logic [OFF_W-1:0]   src_diff;
    logic               off_bad;
    logic [LIT_W-1:0]   lit_dec;
    logic [CNT_W-1:0]   lane_cnt_inc;
    logic [LEN_W-1:0]   len_dec;

    lztd_hist_ram #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (src_reg),
        .rd_data (ram_rd_data)
    );

    // Handshake on the input side.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Circular pointers into the history and the saturating byte count.
    assign wp_inc  = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign src_inc = (src_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : src_reg + 1'b1;
    assign bp_inc  = (bp_reg == BP_W'(HISTORY_DEPTH)) ? bp_reg : bp_reg + 1'b1;

    // Offset check and match source address.
    assign off_full = {1'b0, s_axis_tdata, off_lo_reg};
    assign bp_full  = OFF_W'(bp_reg);
    assign wp_full  = OFF_W'(wp_reg);
    assign off_bad  = (off_full == '0) || (off_full > bp_full);
    assign src_diff = (wp_full >= off_full) ? wp_full - off_full
                                            : wp_full + OFF_W'(HISTORY_DEPTH) - off_full;

    assign lit_dec      = (lit_left_reg != '0) ? lit_left_reg - 1'b1 : lit_left_reg;
    assign lane_cnt_inc = lane_cnt_reg + 1'b1;
    assign len_dec      = len_left_reg - 1'b1;

    // Parser and copy sequencer.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        lit_left_next  = lit_left_reg;
        mlen_next      = mlen_reg;
        off_lo_next    = off_lo_reg;
        wp_next        = wp_reg;
        bp_next        = bp_reg;
        len_left_next  = len_left_reg;
        lane_cnt_next  = lane_cnt_reg;
        last_next      = last_reg;
        src_next       = src_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_load       = 1'b0;
        load_cnt       = '0;
        load_last      = 1'b0;
        load_err       = ERR_NONE;
        lane_wr        = 1'b0;
        ram_wr_en      = 1'b0;
        ram_wr_data    = s_axis_tdata;
        ram_rd_en      = 1'b0;
        for (int i = 0; i < OUT_LANES; i++)
        begin
            load_bytes[i] = '0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (phase_reg)
                        PH_TOKEN:
                        begin
                            if (s_axis_tdata[7])
                            begin
                                mlen_next  = MLEN_W'(s_axis_tdata[6:0]);
                                phase_next = (s_axis_tdata[6:0] == EXT_MARK) ? PH_EXT
                                                                             : PH_OLO;
                            end
                            else
                            begin
                                lit_left_next = s_axis_tdata + 1'b1;
                                phase_next    = PH_LIT;
                            end
                        end
                        PH_LIT:
                        begin
                            out_load      = 1'b1;
                            load_bytes[0] = s_axis_tdata;
                            load_cnt      = VCOUNT_W'(1);
                            load_last     = 1'b1;
                            ram_wr_en     = 1'b1;
                            wp_next       = wp_inc;
                            bp_next       = bp_inc;
                            lit_left_next = lit_dec;
                            phase_next    = (lit_dec == '0) ? PH_TOKEN : PH_LIT;
                        end
                        PH_EXT:
                        begin
                            mlen_next  = mlen_reg + MLEN_W'(s_axis_tdata);
                            phase_next = PH_OLO;
                        end
                        PH_OLO:
                        begin
                            off_lo_next = s_axis_tdata;
                            phase_next  = PH_OHI;
                        end
                        PH_OHI:
                        begin
                            phase_next = PH_TOKEN;
                            mlen_next  = '0;
                            if (off_bad)
                            begin
                                out_load  = 1'b1;
                                load_err  = ERR_OFFSET;
                                load_last = 1'b1;
                            end
                            else
                            begin
                                src_next      = src_diff[AW-1:0];
                                len_left_next = LEN_W'(mlen_reg) + MIN_MATCH;
                                lane_cnt_next = '0;
                                last_next     = s_axis_tlast;
                                state_next    = ST_RD;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_TOKEN;
                        end
                    endcase

                    // End of frame, unless a match copy still has to run first.
                    if (s_axis_tlast && (state_next == ST_IDLE))
                    begin
                        if (phase_next != PH_TOKEN)
                        begin
                            if (out_load)
                            begin
                                // The literal byte goes first; the error item follows.
                                load_last  = 1'b0;
                                state_next = ST_TRUNC;
                            end
                            else
                            begin
                                out_load  = 1'b1;
                                load_err  = ERR_TRUNC;
                                load_last = 1'b1;
                            end
                        end
                        phase_next    = PH_TOKEN;
                        lit_left_next = '0;
                        mlen_next     = '0;
                        off_lo_next   = '0;
                        wp_next       = '0;
                        bp_next       = '0;
                    end
                end
            end
            ST_TRUNC:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_err   = ERR_TRUNC;
                    load_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                // Take the byte just read, append it to the history and to the lanes.
                lane_wr       = 1'b1;
                ram_wr_en     = 1'b1;
                ram_wr_data   = ram_rd_data;
                wp_next       = wp_inc;
                bp_next       = bp_inc;
                src_next      = src_inc;
                len_left_next = len_dec;
                lane_cnt_next = lane_cnt_inc;
                if ((lane_cnt_inc == CNT_W'(OUT_LANES)) || (len_dec == '0))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    for (int i = 0; i < OUT_LANES; i++)
                    begin
                        load_bytes[i] = (CNT_W'(i) < lane_cnt_reg) ? lane_reg[i] : '0;
                    end
                    load_cnt      = VCOUNT_W'(lane_cnt_reg);
                    load_last     = (len_left_reg == '0);
                    lane_cnt_next = '0;
                    if (len_left_reg == '0)
                    begin
                        state_next = ST_IDLE;
                        if (last_reg)
                        begin
                            last_next     = 1'b0;
                            phase_next    = PH_TOKEN;
                            lit_left_next = '0;
                            mlen_next     = '0;
                            off_lo_next   = '0;
                            wp_next       = '0;
                            bp_next       = '0;
                        end
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_TOKEN;
            lit_left_reg  <= '0;
            mlen_reg      <= '0;
            off_lo_reg    <= '0;
            wp_reg        <= '0;
            bp_reg        <= '0;
            len_left_reg  <= '0;
            lane_cnt_reg  <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            lit_left_reg  <= lit_left_next;
            mlen_reg      <= mlen_next;
            off_lo_reg    <= off_lo_next;
            wp_reg        <= wp_next;
            bp_reg        <= bp_next;
            len_left_reg  <= len_left_next;
            lane_cnt_reg  <= lane_cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: copy source, lane buffer and output register.
    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        if (lane_wr)
        begin
            lane_reg[lane_cnt_reg[LANE_W-1:0]] <= ram_rd_data;
        end
        if (out_load)
        begin
            out_byte_reg <= load_bytes;
            out_cnt_reg  <= load_cnt;
            out_last_reg <= load_last;
            out_err_reg  <= load_err;
        end
    end

    // Output packing.
    always_comb
    begin
        m_axis_tdata = '0;
        for (int i = 0; i < OUT_LANES; i++)
        begin
            m_axis_tdata[i*BYTE_W +: BYTE_W] = out_byte_reg[i];
        end
        m_axis_tdata[OUT_LANES*BYTE_W +: VCOUNT_W] = out_cnt_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_err_reg;

    // A history read is always consumed in the following cycle.
    a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |=> (state_reg == ST_WR))
        else $error("history read not followed by write-back");

    // A match result always carries at least one byte and never more than the lanes.
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ((lane_cnt_reg != '0)
                                    && (lane_cnt_reg <= CNT_W'(OUT_LANES))))
        else $error("match result with bad lane count");

    // An error item carries no bytes and closes the run of its input item.
    a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_err_reg != ERR_NONE)) |-> ((out_cnt_reg == '0)
                                                          && out_last_reg))
        else $error("error item with bytes or without end of run");

endmodule
